/* design/rpf_pkg.sv */
// rpf_pkg: shared types and constants for the radio packet framer
// no dependencies; imported by every other file of the block except rpf_if

package rpf_pkg;

    // framer mode, also reported on every result beat
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } t_mode;

    // input command codes
    typedef enum logic [2:0] {
        CMD_EVENT = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_POLL  = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    // radio command words
    localparam logic [15:0] RC_SLEEP  = 16'h8201;
    localparam logic [15:0] RC_TXON   = 16'h823D;
    localparam logic [15:0] RC_RXON   = 16'h82D9;
    localparam logic [15:0] RC_TXBYTE = 16'hB800;

    // framing bytes
    localparam logic [7:0] PREAMBLE_BYTE = 8'h2D;
    localparam logic [7:0] TRAILER_BYTE  = 8'hAA;

    // buffer access for one item: at most one read or one write
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_mem_req;

    // per-item result info handed from the control stage to the output stage
    typedef struct packed {
        logic [1:0]  npend;     // radio commands issued by the item
        logic [15:0] cmd0;
        logic [15:0] cmd1;
        logic        mem_cmd0;  // low byte of cmd0 comes from the buffer read
        logic        mem_read;  // read_data comes from the buffer read
        logic        accepted;
        logic        ready;
        logic [7:0]  rlen;
        logic [1:0]  mode_now;
    } t_item_info;

endpackage

/* design/rpf_if.sv */
// rpf_if: valid/ready channel interfaces for item beats and result beats
// no dependencies; rpf_pkg is not imported here

interface rpf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;

    modport source (output valid, cmd, data_byte, byte_index, frame_length, input ready);
    modport sink   (input valid, cmd, data_byte, byte_index, frame_length, output ready);
endinterface

interface rpf_out_if;
    logic        valid;
    logic        ready;
    logic        radio_cmd_valid;
    logic [15:0] radio_cmd;
    logic        last;
    logic        accepted;
    logic        frame_ready;
    logic [7:0]  frame_len;
    logic [7:0]  read_data;
    logic [1:0]  mode_now;

    modport source (output valid, radio_cmd_valid, radio_cmd, last, accepted, frame_ready,
                    frame_len, read_data, mode_now, input ready);
    modport sink   (input valid, radio_cmd_valid, radio_cmd, last, accepted, frame_ready,
                    frame_len, read_data, mode_now, output ready);
endinterface

/* design/rpf_mem.sv */
// rpf_mem: frame buffer, one synchronous port, registered read data
// depends on rpf_pkg for the access request type

module rpf_mem #(
    parameter int MAX_FRAME = 250
) (
    input  logic              i_clk,
    input  rpf_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_data
);
    import rpf_pkg::*;

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    logic [7:0] r_mem [MAX_FRAME];
    logic [7:0] r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/rpf_ctrl.sv */
// rpf_ctrl: framer state (mode, tx step, index, length, sync byte) and item decode
// depends on rpf_pkg; drives the buffer request and the per-item result info

module rpf_ctrl #(
    parameter int MAX_FRAME = 250
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_data_byte,
    input  logic [7:0]          i_byte_index,
    input  logic [7:0]          i_frame_length,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    output rpf_pkg::t_mem_req   o_mem_req,
    output rpf_pkg::t_item_info o_info
);
    import rpf_pkg::*;

    localparam logic [8:0] MAX9 = 9'(MAX_FRAME);

    t_mode      r_mode, n_mode;
    logic [8:0] r_tx_step, n_tx_step;
    logic [7:0] r_buf_index, n_buf_index;
    logic [7:0] r_buf_len, n_buf_len;
    logic [7:0] r_sync_byte;

    logic       wr, rd;
    logic [7:0] idx_inc;
    logic [8:0] tx_d;
    logic       rx_len_phase, rx_drop, rx_store, rx_done;
    logic       tx_payload, tx_end;
    logic       send_ok, send_kill_rx, send_go;
    logic       poll_done;
    logic       idx_ok;

    // shared decode of the current state
    assign idx_inc      = r_buf_index + 8'd1;
    assign rx_len_phase = (r_buf_index == 8'd0) && (r_buf_len == 8'd0);
    assign rx_drop      = rx_len_phase && ({1'b0, i_data_byte} > MAX9);
    assign rx_store     = !rx_len_phase && (r_buf_index < r_buf_len)
                          && ({1'b0, r_buf_index} < MAX9);
    assign rx_done      = rx_store && (idx_inc >= r_buf_len);
    assign tx_d         = r_tx_step - 9'd3;
    assign tx_payload   = (r_tx_step >= 9'd3) && (tx_d < {1'b0, r_buf_len}) && (tx_d < MAX9);
    assign tx_end       = (r_tx_step >= 9'd3) && !tx_payload && (tx_d != {1'b0, r_buf_len});
    assign send_ok      = {1'b0, i_frame_length} <= MAX9;
    assign send_kill_rx = (r_mode == MODE_RX) && (r_buf_index == 8'd0);
    assign send_go      = send_ok && (send_kill_rx || (r_mode == MODE_IDLE));
    assign poll_done    = (r_mode == MODE_RX) && (r_buf_index >= r_buf_len)
                          && (r_buf_index != 8'd0);
    assign idx_ok       = {1'b0, i_byte_index} < MAX9;

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_tx_step   = r_tx_step;
        n_buf_index = r_buf_index;
        n_buf_len   = r_buf_len;
        unique case (i_cmd)
            CMD_EVENT: begin
                if (r_mode == MODE_RX) begin
                    if (rx_len_phase) begin
                        if (rx_drop) begin
                            n_buf_len = 8'd0;
                            n_mode    = MODE_IDLE;
                        end else begin
                            n_buf_len = i_data_byte;
                        end
                    end else if (rx_store) begin
                        n_buf_index = idx_inc;
                    end
                end else if (r_mode == MODE_TX) begin
                    n_tx_step = r_tx_step + 9'd1;
                    if (tx_end) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            CMD_SEND: begin
                if (send_go) begin
                    n_buf_index = 8'd0;
                    n_buf_len   = i_frame_length;
                    n_tx_step   = 9'd0;
                    n_mode      = MODE_TX;
                end
            end
            CMD_POLL: begin
                if (poll_done || (r_mode == MODE_IDLE)) begin
                    n_buf_index = 8'd0;
                    n_buf_len   = 8'd0;
                    n_mode      = poll_done ? MODE_IDLE : MODE_RX;
                end
            end
            default: begin
            end
        endcase
    end

    // result info and buffer access
    always_comb begin
        o_info          = '0;
        o_info.mode_now = n_mode;
        wr              = 1'b0;
        rd              = 1'b0;
        o_mem_req.addr  = i_byte_index;
        o_mem_req.wdata = i_data_byte;
        unique case (i_cmd)
            CMD_EVENT: begin
                if (r_mode == MODE_RX) begin
                    if (rx_len_phase) begin
                        if (rx_drop) begin
                            o_info.npend = 2'd1;
                            o_info.cmd0  = RC_SLEEP;
                        end
                    end else if (rx_store) begin
                        wr             = 1'b1;
                        o_mem_req.addr = r_buf_index;
                        if (rx_done) begin
                            o_info.npend = 2'd1;
                            o_info.cmd0  = RC_SLEEP;
                        end
                    end
                end else if (r_mode == MODE_TX) begin
                    o_info.npend = 2'd1;
                    if (r_tx_step == 9'd0) begin
                        o_info.cmd0 = RC_TXBYTE | {8'd0, PREAMBLE_BYTE};
                    end else if (r_tx_step == 9'd1) begin
                        o_info.cmd0 = RC_TXBYTE | {8'd0, r_sync_byte};
                    end else if (r_tx_step == 9'd2) begin
                        o_info.cmd0 = RC_TXBYTE | {8'd0, r_buf_len};
                    end else if (tx_payload) begin
                        rd              = 1'b1;
                        o_mem_req.addr  = tx_d[7:0];
                        o_info.mem_cmd0 = 1'b1;
                        o_info.cmd0     = RC_TXBYTE;
                    end else if (tx_end) begin
                        o_info.npend = 2'd2;
                        o_info.cmd0  = RC_SLEEP;
                        o_info.cmd1  = RC_TXBYTE | {8'd0, TRAILER_BYTE};
                    end else begin
                        o_info.cmd0 = RC_TXBYTE | {8'd0, TRAILER_BYTE};
                    end
                end
            end
            CMD_WRITE: begin
                if (idx_ok && (r_mode != MODE_TX)) begin
                    wr              = 1'b1;
                    o_info.accepted = 1'b1;
                end
            end
            CMD_SEND: begin
                if (send_go) begin
                    o_info.accepted = 1'b1;
                    if (send_kill_rx) begin
                        o_info.npend = 2'd2;
                        o_info.cmd0  = RC_SLEEP;
                        o_info.cmd1  = RC_TXON;
                    end else begin
                        o_info.npend = 2'd1;
                        o_info.cmd0  = RC_TXON;
                    end
                end
            end
            CMD_POLL: begin
                if (poll_done) begin
                    o_info.ready = 1'b1;
                    o_info.rlen  = r_buf_len;
                end else if (r_mode == MODE_IDLE) begin
                    o_info.npend = 2'd1;
                    o_info.cmd0  = RC_RXON;
                end
            end
            CMD_READ: begin
                if (idx_ok) begin
                    rd              = 1'b1;
                    o_info.mem_read = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_mem_req.wr_en = i_accept && wr;
        o_mem_req.rd_en = i_accept && rd;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_tx_step   <= 9'd0;
            r_buf_index <= 8'd0;
            r_buf_len   <= 8'd0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_tx_step   <= n_tx_step;
            r_buf_index <= n_buf_index;
            r_buf_len   <= n_buf_len;
        end
    end

    // sync byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= 8'd0;
        end else if (i_cfg_we) begin
            r_sync_byte <= i_cfg_wdata;
        end
    end

    // stored length never exceeds the buffer
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_buf_len} <= MAX9)
        else $error("buffer length over maximum");

    // receive index never passes the length
    a_rx_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RX) |-> (r_buf_index <= r_buf_len))
        else $error("receive index past length");

    // buffer accesses stay inside the buffer
    a_mem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.wr_en || o_mem_req.rd_en) |-> ({1'b0, o_mem_req.addr} < MAX9))
        else $error("buffer access out of range");

endmodule

/* design/rpf_out.sv */
// rpf_out: read-latency stage and output register, splits items into result beats
// depends on rpf_pkg for the item info type and the transmit byte command

module rpf_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  rpf_pkg::t_item_info i_info,
    input  logic [7:0]          i_rd_data,
    output logic                o_in_ready,
    rpf_out_if.source           o_out
);
    import rpf_pkg::*;

    logic        r_a_v;
    t_item_info  r_a_info;
    logic        r_b_v;
    logic        r_b_sel;
    logic [1:0]  r_b_npend;
    logic [15:0] r_b_cmd0;
    logic [15:0] r_b_cmd1;
    logic        r_b_accepted;
    logic        r_b_ready;
    logic [7:0]  r_b_rlen;
    logic [7:0]  r_b_rdata;
    logic [1:0]  r_b_mode;

    logic b_is_last, b_beat, b_last_taken, a_move, cmd_valid;

    // beat bookkeeping
    assign b_is_last    = r_b_sel == (r_b_npend == 2'd2);
    assign b_beat       = r_b_v && o_out.ready;
    assign b_last_taken = b_beat && b_is_last;
    assign a_move       = r_a_v && (!r_b_v || b_last_taken);
    assign o_in_ready   = !r_a_v || a_move;
    assign cmd_valid    = {1'b0, r_b_sel} < r_b_npend;

    // stage valid flags and beat select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_b_sel <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_v <= 1'b1;
            end else if (a_move) begin
                r_a_v <= 1'b0;
            end
            if (a_move) begin
                r_b_v   <= 1'b1;
                r_b_sel <= 1'b0;
            end else if (b_last_taken) begin
                r_b_v <= 1'b0;
            end else if (b_beat) begin
                r_b_sel <= 1'b1;
            end
        end
    end

    // payload: item info, then resolved results with buffer data merged
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_info <= i_info;
        end
        if (a_move) begin
            r_b_npend    <= r_a_info.npend;
            r_b_cmd0     <= r_a_info.mem_cmd0 ? (RC_TXBYTE | {8'd0, i_rd_data})
                                              : r_a_info.cmd0;
            r_b_cmd1     <= r_a_info.cmd1;
            r_b_accepted <= r_a_info.accepted;
            r_b_ready    <= r_a_info.ready;
            r_b_rlen     <= r_a_info.rlen;
            r_b_rdata    <= r_a_info.mem_read ? i_rd_data : 8'd0;
            r_b_mode     <= r_a_info.mode_now;
        end
    end

    // result beat
    assign o_out.valid           = r_b_v;
    assign o_out.radio_cmd_valid = cmd_valid;
    assign o_out.radio_cmd       = !cmd_valid ? 16'd0 : (r_b_sel ? r_b_cmd1 : r_b_cmd0);
    assign o_out.last            = b_is_last;
    assign o_out.accepted        = r_b_accepted;
    assign o_out.frame_ready     = r_b_ready;
    assign o_out.frame_len       = r_b_rlen;
    assign o_out.read_data       = r_b_rdata;
    assign o_out.mode_now        = r_b_mode;

    // second beat only exists for two-command items
    a_sel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && r_b_sel) |-> (r_b_npend == 2'd2))
        else $error("second beat on a single-result item");

    // a taken first beat of a two-command item is followed by its second beat
    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_beat && !b_is_last && !a_move) |=> (r_b_v && r_b_sel))
        else $error("second beat lost");

    // an empty read stage always takes a new item
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_v |-> o_in_ready)
        else $error("stalled with an empty read stage");

endmodule

/* design/radio_packet_framer.sv */
// radio_packet_framer: length-prefixed packet framer for a FIFO radio
// depends on rpf_pkg, rpf_if, rpf_ctrl, rpf_mem and rpf_out
// latency: an item passes the read stage register, then the output register,
//   before its first result beat can be taken
// throughput: one item per cycle unless the output stalls; an item with two radio
//   commands holds the input for two result beats of the single output register
// reset: synchronous, clears mode, counters, sync byte and stage flags;
//   buffer contents stay undefined until written, no clearing pass

module radio_packet_framer #(
    parameter int MAX_FRAME = 250
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    rpf_in_if.sink     i_in,
    rpf_out_if.source  o_out
);
    import rpf_pkg::*;

    logic       w_accept;
    logic       w_in_ready;
    t_mem_req   w_mem_req;
    t_item_info w_info;
    logic [7:0] w_rd_data;

    // input handshake
    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // state and decode
    rpf_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cmd          (i_in.cmd),
        .i_data_byte    (i_in.data_byte),
        .i_byte_index   (i_in.byte_index),
        .i_frame_length (i_in.frame_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_mem_req      (w_mem_req),
        .o_info         (w_info)
    );

    // frame buffer
    rpf_mem #(
        .MAX_FRAME (MAX_FRAME)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    // result stages
    rpf_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_info     (w_info),
        .i_rd_data  (w_rd_data),
        .o_in_ready (w_in_ready),
        .o_out      (o_out)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for radio_packet_framer, with a built-in framer predictor
// depends on rpf_pkg, rpf_if and the radio_packet_framer top level

module testbench;
    import rpf_pkg::*;

    localparam int MAX_FRAME    = 250;
    localparam int MAX_GAP      = 6;
    localparam int QUIET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 50;

    // command codes the block must ignore
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall;

    // one expected result beat
    typedef struct {
        logic        cmd_valid;
        logic [15:0] radio_cmd;
        logic        last;
        logic        accepted;
        logic        frame_ready;
        logic [7:0]  frame_len;
        logic [7:0]  read_data;
        logic [1:0]  mode_now;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    rpf_in_if  in_ch ();
    rpf_out_if out_ch ();

    radio_packet_framer #(
        .MAX_FRAME(MAX_FRAME)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predicted framer state
    t_mode      pred_mode;
    logic [8:0] pred_step;
    logic [7:0] pred_index;
    logic [7:0] pred_len;
    logic [7:0] pred_sync;
    logic [7:0] pred_buf [MAX_FRAME];

    t_result expected_beats [$];

    int n_items       = 0;
    int n_beats       = 0;
    int n_errors      = 0;
    int n_cycles      = 0;
    int n_tx_frames   = 0;
    int n_rx_frames   = 0;
    int n_dropped     = 0;
    int n_sync_writes = 0;
    int burst_left    = 0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("run stopped at cycle limit with %0d beats outstanding",
                     expected_beats.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT) begin
            $display("mismatch %s: got %h expected %h at beat %0d (t=%0t)",
                     what, got, want, n_beats, $realtime);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // framer predictor: updates state and queues the result beats of one item
    task automatic predict_item(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [7:0] idx, input logic [7:0] flen);
        logic [15:0] cmds [$];
        logic        acc;
        logic        rdy;
        logic [7:0]  rlen;
        logic [7:0]  rdata;
        logic [8:0]  step;
        logic [8:0]  pos;
        logic [7:0]  tx_out;
        int          nbeats;
        t_result     beat;
        acc   = 1'b0;
        rdy   = 1'b0;
        rlen  = 8'h00;
        rdata = 8'h00;
        case (cmd)
            CMD_EVENT: begin
                if (pred_mode == MODE_RX) begin
                    if (pred_index == 0 && pred_len == 0) begin
                        // first nonzero byte is the length, oversize drops the frame
                        if (data > MAX_FRAME) begin
                            pred_mode = MODE_IDLE;
                            cmds.push_back(RC_SLEEP);
                            n_dropped++;
                        end else begin
                            pred_len = data;
                        end
                    end else if (pred_index < pred_len && pred_index < MAX_FRAME) begin
                        pred_buf[pred_index] = data;
                        pred_index++;
                        if (pred_index >= pred_len) begin
                            cmds.push_back(RC_SLEEP);
                        end
                    end
                end else if (pred_mode == MODE_TX) begin
                    // next byte of the outgoing frame
                    step      = pred_step;
                    pred_step = step + 9'd1;
                    if (step == 0) begin
                        tx_out = PREAMBLE_BYTE;
                    end else if (step == 1) begin
                        tx_out = pred_sync;
                    end else if (step == 2) begin
                        tx_out = pred_len;
                    end else begin
                        pos = step - 9'd3;
                        if (pos < pred_len && pos < MAX_FRAME) begin
                            tx_out = pred_buf[pos[7:0]];
                        end else if (pos == pred_len) begin
                            tx_out = TRAILER_BYTE;
                        end else begin
                            tx_out    = TRAILER_BYTE;
                            pred_mode = MODE_IDLE;
                            cmds.push_back(RC_SLEEP);
                            n_tx_frames++;
                        end
                    end
                    cmds.push_back(RC_TXBYTE | {8'h00, tx_out});
                end
            end
            CMD_WRITE: begin
                if (idx < MAX_FRAME && pred_mode != MODE_TX) begin
                    pred_buf[idx] = data;
                    acc = 1'b1;
                end
            end
            CMD_SEND: begin
                if (flen <= MAX_FRAME) begin
                    // receiver with no payload yet gives way to the send
                    if (pred_mode == MODE_RX && pred_index == 0) begin
                        pred_mode = MODE_IDLE;
                        cmds.push_back(RC_SLEEP);
                    end
                    if (pred_mode == MODE_IDLE) begin
                        pred_index = 8'h00;
                        pred_len   = flen;
                        pred_step  = 9'd0;
                        pred_mode  = MODE_TX;
                        cmds.push_back(RC_TXON);
                        acc = 1'b1;
                    end
                end
            end
            CMD_POLL: begin
                if (pred_mode == MODE_RX && pred_index >= pred_len && pred_index != 0) begin
                    pred_mode  = MODE_IDLE;
                    rdy        = 1'b1;
                    rlen       = pred_len;
                    pred_index = 8'h00;
                    pred_len   = 8'h00;
                    n_rx_frames++;
                end else if (pred_mode == MODE_IDLE) begin
                    pred_index = 8'h00;
                    pred_len   = 8'h00;
                    pred_mode  = MODE_RX;
                    cmds.push_back(RC_RXON);
                end
            end
            CMD_READ: begin
                if (idx < MAX_FRAME) begin
                    rdata = pred_buf[idx];
                end
            end
            default: begin
            end
        endcase

        // one beat per radio command, or a single beat without one
        nbeats = (cmds.size() > 0) ? cmds.size() : 1;
        for (int k = 0; k < nbeats; k++) begin
            beat.cmd_valid   = (k < cmds.size());
            beat.radio_cmd   = (k < cmds.size()) ? cmds[k] : 16'h0000;
            beat.last        = (k == nbeats - 1);
            beat.accepted    = acc;
            beat.frame_ready = rdy;
            beat.frame_len   = rlen;
            beat.read_data   = rdata;
            beat.mode_now    = pred_mode;
            expected_beats.push_back(beat);
        end
    endtask

    // drive one item beat, honoring the burst/gap pattern, and predict it on acceptance
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                             input logic [7:0] idx, input logic [7:0] flen);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd;
        in_ch.data_byte    <= data;
        in_ch.byte_index   <= idx;
        in_ch.frame_length <= flen;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(cmd, data, idx, flen);
        n_items++;
    endtask

    task automatic fifo_event(input logic [7:0] data);
        send_item(CMD_EVENT, data, 8'($urandom), 8'($urandom));
    endtask

    task automatic write_byte(input logic [7:0] idx, input logic [7:0] data);
        send_item(CMD_WRITE, data, idx, 8'($urandom));
    endtask

    task automatic start_send(input logic [7:0] flen);
        send_item(CMD_SEND, 8'($urandom), 8'($urandom), flen);
    endtask

    task automatic poll_rx();
        send_item(CMD_POLL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic read_byte(input logic [7:0] idx);
        send_item(CMD_READ, 8'($urandom), idx, 8'($urandom));
    endtask

    // any command, lengths either oversize or short to keep frames cheap
    task automatic noise_item();
        logic [7:0] flen;
        flen = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(MAX_FRAME + 1, 8'hFF))
                                           : 8'($urandom_range(0, 15));
        send_item(3'($urandom_range(CMD_EVENT, CMD_LAST_UNUSED)), 8'($urandom),
                  8'($urandom), flen);
    endtask

    // wait until every expected beat has come and the pipeline has drained
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        pred_sync = value;
        n_sync_writes++;
    endtask

    // bring the framer back to idle from whatever a sequence left behind
    task automatic settle_idle();
        while (pred_mode != MODE_IDLE) begin
            if (pred_mode == MODE_TX) begin
                fifo_event(8'($urandom));
            end else if (pred_index >= pred_len && pred_index != 0) begin
                poll_rx();
            end else if (pred_index == 0 && pred_len == 0) begin
                fifo_event(8'($urandom_range(MAX_FRAME + 1, 8'hFF)));
            end else begin
                fifo_event(8'($urandom));
            end
        end
    endtask

    function automatic int payload_length();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    endfunction

    task automatic tx_sequence();
        int flen;
        int n_events;
        settle_idle();
        repeat ($urandom_range(0, 3)) write_byte(8'($urandom_range(0, 15)), 8'($urandom));
        flen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
        start_send(8'(flen));
        n_events = flen + 5;
        // now and then cut the frame short and leave the rest to the next sequence
        if ($urandom_range(0, 9) == 0) begin
            n_events = $urandom_range(0, flen + 4);
        end
        repeat (n_events) begin
            if ($urandom_range(0, 7) == 0) begin
                noise_item();
            end
            fifo_event(8'($urandom));
        end
    endtask

    task automatic rx_sequence();
        int rlen;
        int kind;
        settle_idle();
        poll_rx();
        kind = $urandom_range(0, 19);
        // oversize length byte drops the frame
        if (kind == 0) begin
            fifo_event(8'($urandom_range(MAX_FRAME + 1, 8'hFF)));
            return;
        end
        // send before any byte arrived
        if (kind == 1) begin
            start_send(8'($urandom_range(0, 8)));
            return;
        end
        if (kind < 5) begin
            fifo_event(8'h00);
        end
        rlen = payload_length();
        fifo_event(8'(rlen));
        // send after the length but before the payload
        if (kind == 5) begin
            start_send(8'($urandom_range(0, 8)));
            return;
        end
        for (int i = 0; i < rlen; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                poll_rx();
            end
            if ($urandom_range(0, 19) == 0) begin
                noise_item();
            end
            fifo_event(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) fifo_event(8'($urandom));
        poll_rx();
        repeat ($urandom_range(0, 3)) read_byte(8'($urandom_range(0, rlen - 1)));
    endtask

    // every buffer entry gets written, extremes at both ends
    task automatic test_buffer_fill();
        for (int i = 0; i < MAX_FRAME; i++) begin
            write_byte(8'(i), (i == 0) ? 8'h00 : (i == MAX_FRAME - 1) ? 8'hFF : 8'($urandom));
        end
    endtask

    task automatic test_buffer_access();
        read_byte(8'h00);
        read_byte(8'(MAX_FRAME - 1));
        read_byte(8'(MAX_FRAME));
        read_byte(8'hFF);
        write_byte(8'(MAX_FRAME), 8'($urandom));
        write_byte(8'hFF, 8'($urandom));
        read_byte(8'(MAX_FRAME - 1));
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) begin
            send_item(3'(c), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_transmit_cases();
        fifo_event(8'($urandom));
        start_send(8'(MAX_FRAME + 1));
        start_send(8'hFF);
        // empty frame, with writes, polls and sends refused while it goes out
        start_send(8'h00);
        write_byte(8'h00, 8'($urandom));
        poll_rx();
        start_send(8'h01);
        repeat (5) fifo_event(8'($urandom));
    endtask

    task automatic test_receive_cases();
        poll_rx();
        poll_rx();
        fifo_event(8'h00);
        fifo_event(8'(MAX_FRAME + 1));
        // length seen, no payload yet: send puts the receiver to sleep
        poll_rx();
        fifo_event(8'h02);
        start_send(8'h01);
        repeat (6) fifo_event(8'($urandom));
        // one-byte frame, trailing byte ignored, late send refused
        poll_rx();
        fifo_event(8'h01);
        fifo_event(8'hFF);
        fifo_event(8'h00);
        start_send(8'h01);
        write_byte(8'h05, 8'($urandom));
        poll_rx();
        read_byte(8'h00);
    endtask

    task automatic test_full_frames();
        settle_idle();
        start_send(8'(MAX_FRAME));
        repeat (MAX_FRAME + 5) fifo_event(8'($urandom));
        poll_rx();
        fifo_event(8'(MAX_FRAME));
        repeat (MAX_FRAME + 1) fifo_event(8'($urandom));
        poll_rx();
        read_byte(8'(MAX_FRAME - 1));
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                tx_sequence();
            end else if (pick < 8) begin
                rx_sequence();
            end else begin
                repeat ($urandom_range(1, 6)) noise_item();
            end
        end
    endtask

    // receiver stalls, switching style every so often
    t_stall     stall_style   = STALL_NONE;
    int         stall_left    = 0;
    logic [7:0] stall_pattern = 8'hFF;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style   = t_stall'($urandom_range(STALL_NONE, STALL_HEAVY));
            stall_left    = $urandom_range(20, 200);
            stall_pattern = 8'($urandom) | 8'h01;
        end else begin
            stall_left--;
        end
        case (stall_style)
            STALL_NONE: out_ch.ready <= 1'b1;
            STALL_COIN: out_ch.ready <= ($urandom_range(0, 1) == 1);
            STALL_PATTERN: begin
                out_ch.ready  <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_beats++;
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected, radio_cmd", out_ch.radio_cmd,
                                16'h0000);
            end else begin
                want = expected_beats.pop_front();
                check_field("radio_cmd_valid", 16'(out_ch.radio_cmd_valid),
                            16'(want.cmd_valid));
                check_field("radio_cmd", out_ch.radio_cmd, want.radio_cmd);
                check_field("last", 16'(out_ch.last), 16'(want.last));
                check_field("accepted", 16'(out_ch.accepted), 16'(want.accepted));
                check_field("frame_ready", 16'(out_ch.frame_ready), 16'(want.frame_ready));
                check_field("frame_len", 16'(out_ch.frame_len), 16'(want.frame_len));
                check_field("read_data", 16'(out_ch.read_data), 16'(want.read_data));
                check_field("mode_now", 16'(out_ch.mode_now), 16'(want.mode_now));
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 8'h00;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_EVENT;
        in_ch.data_byte    = 8'h00;
        in_ch.byte_index   = 8'h00;
        in_ch.frame_length = 8'h00;
        pred_mode          = MODE_IDLE;
        pred_step          = 9'd0;
        pred_index         = 8'h00;
        pred_len           = 8'h00;
        pred_sync          = 8'h00;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_sync(8'hFF);
        test_buffer_fill();
        test_buffer_access();
        test_transmit_cases();
        test_receive_cases();
        write_sync(8'h00);
        test_full_frames();
        write_sync(8'($urandom));
        test_random_traffic(60);
        write_sync(8'hFF);
        test_random_traffic(60);
        write_sync(8'($urandom));
        test_random_traffic(60);
        write_sync(8'h00);
        test_random_traffic(60);
        wait_quiet();

        $display("covered %0d items and %0d result beats: %0d frames sent,",
                 n_items, n_beats, n_tx_frames);
        $display("%0d received, %0d dropped, sync byte written %0d times, %0d mismatches",
                 n_rx_frames, n_dropped, n_sync_writes, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
